// ----- rtl/magaw_pkg.sv -----
// shared types and constants of the gather address walker
// no dependencies

package magaw_pkg;

    localparam int MAX_AXES_DEF    = 3;
    localparam int TABLE_DEPTH_DEF = 64;
    localparam int AXIS_BITS_DEF   = 16;

    localparam int CFG_AXES   = 3;
    localparam int SIZE_W     = 16;
    localparam int CNT_W      = 16;
    localparam int LCNT_W     = 7;
    localparam int MODE_W     = 2 * CFG_AXES;
    localparam int OFF_W      = 48;
    localparam int OP_W       = 2;
    localparam int AXSEL_W    = 2;
    localparam int SLOT_IN_W  = 6;
    localparam int VAL_W      = 17;
    localparam int STAT_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD    = 2'd0,
        OP_STEP    = 2'd1,
        OP_RESTART = 2'd2
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        MODE_ALL    = 2'd0,
        MODE_SINGLE = 2'd1,
        MODE_LIST   = 2'd2
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RANK  = 3'd0,
        CFG_SIZE0 = 3'd1,
        CFG_SIZE1 = 3'd2,
        CFG_SIZE2 = 3'd3,
        CFG_MODE  = 3'd4,
        CFG_LCNT0 = 3'd5,
        CFG_LCNT1 = 3'd6,
        CFG_LCNT2 = 3'd7
    } t_cfg_reg;

    typedef struct packed {
        logic [SIZE_W-1:0] size;
        t_mode             mode;
        logic [CNT_W-1:0]  cnt;
    } t_axis_cfg;

endpackage

// ----- rtl/multi_axis_gather_address_walker_core.sv -----
// gather address walker: a load goes through S_LOAD, a step through S_CHECK, S_MAC
// (one table read and one multiply-add per used axis) and S_DONE before its result;
// an empty selection ends in S_CHECK; a restart clears the walk and shows no result.
// a new request is taken in the cycle its predecessor's result is shown; the
// receiver cannot stall. synchronous active-low reset clears the walk and control.
// depends on magaw_pkg, magaw_cfg, magaw_load, magaw_ram

module multi_axis_gather_address_walker_core
    import magaw_pkg::*;
#(
    parameter int MAX_AXES    = MAX_AXES_DEF,
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int AXIS_BITS   = AXIS_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [OP_W-1:0]         i_operation,
    input  logic [AXSEL_W-1:0]      i_axis_select,
    input  logic [SLOT_IN_W-1:0]    i_slot,
    input  logic signed [VAL_W-1:0] i_index_value,
    output logic                    o_strobe,
    output logic [OFF_W-1:0]        o_source_offset,
    output logic                    o_last,
    output logic [STAT_W-1:0]       o_status,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int AX_W      = (MAX_AXES > 1) ? $clog2(MAX_AXES) : 1;
    localparam int SLOT_W    = $clog2(TABLE_DEPTH);
    localparam int RAM_DEPTH = MAX_AXES * TABLE_DEPTH;
    localparam int ADDR_W    = $clog2(RAM_DEPTH);
    localparam int RANK_W    = $clog2(MAX_AXES + 1);
    localparam int AXB       = (AXIS_BITS > SIZE_W) ? AXIS_BITS : SIZE_W;
    localparam int MUL_RAW   = (MAX_AXES - 1) * AXB;
    localparam int MUL_W     = (MUL_RAW < 1) ? 1 : ((MUL_RAW > OFF_W) ? OFF_W : MUL_RAW);
    localparam int PROD_W    = MUL_W + SIZE_W;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_LOAD  = 5'b00010,
        S_CHECK = 5'b00100,
        S_MAC   = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_strobe, n_strobe;

    logic [AXSEL_W-1:0]      r_axsel;
    logic [SLOT_IN_W-1:0]    r_slot;
    logic signed [VAL_W-1:0] r_value;

    logic [AXIS_BITS-1:0] r_walk [MAX_AXES];
    logic [AXIS_BITS-1:0] n_walk [MAX_AXES];
    logic [AXIS_BITS-1:0] r_pos  [MAX_AXES];
    logic [AXIS_BITS-1:0] c_pos  [MAX_AXES];
    logic [AX_W-1:0]      r_axis;
    logic [OFF_W-1:0]     r_acc;

    logic [OFF_W-1:0]  r_offset;
    logic              r_last;
    logic [STAT_W-1:0] r_status;

    logic [RANK_W-1:0] w_rank;
    t_axis_cfg         w_axis [MAX_AXES];

    logic                 w_empty;
    logic                 w_wrap;
    logic                 w_mac_last;
    logic [AX_W-1:0]      w_nxt_axis;
    logic [AX_W-1:0]      w_rd_axis;
    logic [AXIS_BITS-1:0] w_rd_pos;
    logic [SLOT_W-1:0]    w_rd_slot;
    logic [AXB-1:0]       w_idx;
    logic [PROD_W-1:0]    w_prod;
    logic [OFF_W-1:0]     w_mac;

    logic                 w_place_ok;
    logic [SIZE_W-1:0]    w_ld_size;
    logic                 w_ld_ok;
    logic [AXIS_BITS-1:0] w_ld_index;

    logic                 w_we;
    logic [ADDR_W-1:0]    w_waddr;
    logic [ADDR_W-1:0]    w_raddr;
    logic [AXIS_BITS-1:0] w_rdata;

    magaw_cfg #(
        .MAX_AXES    (MAX_AXES),
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_rank      (w_rank),
        .o_axis      (w_axis)
    );

    // load path
    always_comb begin
        w_place_ok = (int'(r_axsel) < MAX_AXES) && (int'(r_slot) < TABLE_DEPTH);
        w_ld_size  = '0;
        for (int a = 0; a < MAX_AXES; a++) begin
            if (int'(r_axsel) == a) begin
                w_ld_size = w_axis[a].size;
            end
        end
    end

    magaw_load #(
        .AXIS_BITS (AXIS_BITS)
    ) u_load (
        .i_value    (r_value),
        .i_size     (w_ld_size),
        .i_place_ok (w_place_ok),
        .o_ok       (w_ld_ok),
        .o_index    (w_ld_index)
    );

    assign w_we    = (r_state == S_LOAD) && w_ld_ok;
    assign w_waddr = ADDR_W'(ADDR_W'(AX_W'(r_axsel)) * ADDR_W'(TABLE_DEPTH)
                             + ADDR_W'(SLOT_W'(r_slot)));

    // walk position clamp and empty selection
    always_comb begin
        w_empty = 1'b0;
        for (int a = 0; a < MAX_AXES; a++) begin
            c_pos[a] = (int'(r_walk[a]) < int'(w_axis[a].cnt)) ? r_walk[a] : '0;
            if ((a < int'(w_rank)) && (w_axis[a].cnt == '0)) begin
                w_empty = 1'b1;
            end
        end
    end

    // table read, one axis per cycle
    assign w_nxt_axis = (int'(r_axis) == MAX_AXES - 1) ? '0 : AX_W'(int'(r_axis) + 1);
    assign w_rd_axis  = (r_state == S_CHECK) ? '0 : w_nxt_axis;
    assign w_rd_pos   = (r_state == S_CHECK) ? c_pos[0] : r_pos[w_nxt_axis];
    assign w_rd_slot  = (w_axis[w_rd_axis].mode == MODE_LIST) ? SLOT_W'(w_rd_pos) : '0;
    assign w_raddr    = ADDR_W'(ADDR_W'(w_rd_axis) * ADDR_W'(TABLE_DEPTH)
                                + ADDR_W'(w_rd_slot));

    magaw_ram #(
        .WIDTH (AXIS_BITS),
        .DEPTH (RAM_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_ld_index),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // row-major offset, horner form over the used axes
    assign w_idx      = (w_axis[r_axis].mode == MODE_ALL) ? AXB'(r_pos[r_axis]) : AXB'(w_rdata);
    assign w_prod     = PROD_W'(MUL_W'(r_acc)) * PROD_W'(w_axis[r_axis].size);
    assign w_mac      = OFF_W'(w_prod) + OFF_W'(w_idx);
    assign w_mac_last = (int'(r_axis) + 1) == int'(w_rank);

    // odometer, last axis fastest
    always_comb begin
        w_wrap = 1'b1;
        for (int a = MAX_AXES - 1; a >= 0; a--) begin
            if (a < int'(w_rank)) begin
                if (w_wrap) begin
                    if ((int'(r_pos[a]) + 1) < int'(w_axis[a].cnt)) begin
                        n_walk[a] = AXIS_BITS'(int'(r_pos[a]) + 1);
                        w_wrap    = 1'b0;
                    end else begin
                        n_walk[a] = '0;
                    end
                end else begin
                    n_walk[a] = r_pos[a];
                end
            end else begin
                n_walk[a] = '0;
            end
        end
    end

    // control
    always_comb begin
        n_state  = r_state;
        n_strobe = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (t_op'(i_operation))
                        OP_LOAD: n_state = S_LOAD;
                        OP_STEP: n_state = S_CHECK;
                        default: ;
                    endcase
                end
            end
            S_LOAD: begin
                n_state  = S_IDLE;
                n_strobe = 1'b1;
            end
            S_CHECK: begin
                if (w_empty) begin
                    n_state  = S_IDLE;
                    n_strobe = 1'b1;
                end else begin
                    n_state = S_MAC;
                end
            end
            S_MAC: begin
                if (w_mac_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_state  = S_IDLE;
                n_strobe = 1'b1;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
            for (int a = 0; a < MAX_AXES; a++) begin
                r_walk[a] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            if ((r_state == S_IDLE) && start && (t_op'(i_operation) == OP_RESTART)) begin
                for (int a = 0; a < MAX_AXES; a++) begin
                    r_walk[a] <= '0;
                end
            end else if (r_state == S_DONE) begin
                r_walk <= n_walk;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    r_axsel <= i_axis_select;
                    r_slot  <= i_slot;
                    r_value <= i_index_value;
                end
            end
            S_LOAD: begin
                r_offset <= '0;
                r_last   <= 1'b0;
                r_status <= w_ld_ok ? ST_OK : ST_RANGE;
            end
            S_CHECK: begin
                r_pos  <= c_pos;
                r_axis <= '0;
                r_acc  <= '0;
                if (w_empty) begin
                    r_offset <= '0;
                    r_last   <= 1'b0;
                    r_status <= ST_EMPTY;
                end
            end
            S_MAC: begin
                r_acc  <= w_mac;
                r_axis <= w_nxt_axis;
            end
            S_DONE: begin
                r_offset <= r_acc;
                r_last   <= w_wrap;
                r_status <= ST_OK;
            end
            default: ;
        endcase
    end

    assign busy            = (r_state != S_IDLE);
    assign o_strobe        = r_strobe;
    assign o_source_offset = r_offset;
    assign o_last          = r_last;
    assign o_status        = r_status;

    a_strobe_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ($past(r_state) != S_IDLE))
        else $error("result strobe without preceding work");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("results on consecutive cycles");

    a_mac_axis_in_rank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAC) |-> (int'(r_axis) < int'(w_rank)))
        else $error("offset accumulation past used rank");

    a_empty_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_status == STAT_W'(ST_EMPTY))) |-> (!o_last && (o_source_offset == '0)))
        else $error("empty selection with nonzero offset or last");

endmodule

// ----- rtl/magaw_ram.sv -----
// generic single-port-write, single-port-read ram with registered read data
// no dependencies

module magaw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/magaw_cfg.sv -----
// configuration registers and per-axis decode (mode, selected count, used rank)
// depends on magaw_pkg

module magaw_cfg
    import magaw_pkg::*;
#(
    parameter int MAX_AXES    = MAX_AXES_DEF,
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]              i_cfg_index,
    input  logic [CFG_DATA_W-1:0]             i_cfg_data,
    output logic                              o_cfg_ready,
    output logic [$clog2(MAX_AXES+1)-1:0]     o_rank,
    output t_axis_cfg                         o_axis [MAX_AXES]
);

    localparam int RANK_W = $clog2(MAX_AXES + 1);

    logic [1:0]        r_rank;
    logic [SIZE_W-1:0] r_size [CFG_AXES];
    logic [MODE_W-1:0] r_mode;
    logic [LCNT_W-1:0] r_lcnt [CFG_AXES];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank <= 2'd1;
            for (int a = 0; a < CFG_AXES; a++) begin
                r_size[a] <= SIZE_W'(1);
                r_lcnt[a] <= '0;
            end
            r_mode <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_RANK:  r_rank    <= i_cfg_data[1:0];
                CFG_SIZE0: r_size[0] <= i_cfg_data[SIZE_W-1:0];
                CFG_SIZE1: r_size[1] <= i_cfg_data[SIZE_W-1:0];
                CFG_SIZE2: r_size[2] <= i_cfg_data[SIZE_W-1:0];
                CFG_MODE:  r_mode    <= i_cfg_data[MODE_W-1:0];
                CFG_LCNT0: r_lcnt[0] <= i_cfg_data[LCNT_W-1:0];
                CFG_LCNT1: r_lcnt[1] <= i_cfg_data[LCNT_W-1:0];
                CFG_LCNT2: r_lcnt[2] <= i_cfg_data[LCNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_rank == 2'd0) begin
            o_rank = RANK_W'(1);
        end else if (int'(r_rank) > MAX_AXES) begin
            o_rank = RANK_W'(MAX_AXES);
        end else begin
            o_rank = RANK_W'(r_rank);
        end
    end

    for (genvar a = 0; a < MAX_AXES; a++) begin : g_axis
        if (a < CFG_AXES) begin : g_reg
            t_mode            w_mode;
            logic [CNT_W-1:0] w_cnt;

            always_comb begin
                unique case (t_mode'(r_mode[2*a +: 2]))
                    MODE_SINGLE: begin
                        w_mode = MODE_SINGLE;
                        w_cnt  = CNT_W'(1);
                    end
                    MODE_LIST: begin
                        w_mode = MODE_LIST;
                        w_cnt  = (int'(r_lcnt[a]) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH)
                                                                 : CNT_W'(r_lcnt[a]);
                    end
                    default: begin
                        w_mode = MODE_ALL;
                        w_cnt  = CNT_W'(r_size[a]);
                    end
                endcase
            end

            assign o_axis[a] = '{size: r_size[a], mode: w_mode, cnt: w_cnt};
        end else begin : g_none
            assign o_axis[a] = '{size: '0, mode: MODE_ALL, cnt: '0};
        end
    end

endmodule

// ----- rtl/magaw_load.sv -----
// index normalization for a table load: negative index counts from the axis end
// depends on magaw_pkg

module magaw_load
    import magaw_pkg::*;
#(
    parameter int AXIS_BITS = AXIS_BITS_DEF
) (
    input  logic signed [VAL_W-1:0]  i_value,
    input  logic [SIZE_W-1:0]        i_size,
    input  logic                     i_place_ok,
    output logic                     o_ok,
    output logic [AXIS_BITS-1:0]     o_index
);

    logic signed [VAL_W:0] w_ext;
    logic signed [VAL_W:0] w_norm;

    assign w_ext  = {i_value[VAL_W-1], i_value};
    assign w_norm = i_value[VAL_W-1] ? (w_ext + $signed({2'b00, i_size})) : w_ext;

    assign o_ok    = i_place_ok && !w_norm[VAL_W]
                     && (w_norm[VAL_W-1:0] < {1'b0, i_size});
    assign o_index = AXIS_BITS'(w_norm[SIZE_W-1:0]);

endmodule
